[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the averager RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, held off while reset is asserted.
`define TM_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("averager assertion failed");

// Check a property on every rising edge, reset included.
`define TM_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("averager assertion failed");

`endif

[rtl/core/tmadc_pkg.sv]
// ---------------------------------------------------------------------------
// tmadc_pkg
// Shared constants and types of the two-channel trimmed-mean averager.
// ---------------------------------------------------------------------------
package tmadc_pkg;

  localparam int unsigned SampleWidthDefault = 16;
  localparam int unsigned SettleWidth        = 4;
  localparam int unsigned CountWidth         = 5;
  localparam int unsigned KeepCount          = 10;
  localparam int unsigned GuardBits          = 4;
  localparam int unsigned TrimShift          = 3;

  localparam logic [SettleWidth-1:0] SettleReset = 4'd4;

  // Highest count that can stay in the counter between steps.
  localparam int unsigned MaxHeldCount = (2 ** SettleWidth) - 1 + KeepCount - 1;

  typedef logic [SettleWidth-1:0] settle_t;
  typedef logic [CountWidth-1:0]  count_t;

  // Tag of one result, travels from the accumulator to the output stage.
  typedef struct packed {
    logic channel;
    logic round_done;
  } result_tag_t;

endpackage

[rtl/core/tmadc_in_stage.sv]
// ---------------------------------------------------------------------------
// tmadc_in_stage
// Input register: holds one sample until the accumulator consumes it.
// ---------------------------------------------------------------------------
module tmadc_in_stage #(
  parameter int unsigned SampleWidth = tmadc_pkg::SampleWidthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SampleWidth-1:0] sample_i,
  input  logic                   consume_i,
  output logic                   held_valid_o,
  output logic [SampleWidth-1:0] held_sample_o
);
  import tmadc_pkg::*;

  logic                   valid_q;
  logic [SampleWidth-1:0] sample_q;

  // Stall only while a held sample cannot move on this cycle.
  assign in_stall_o = valid_q & ~consume_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      sample_q <= sample_i;
    end
  end

  assign held_valid_o  = valid_q;
  assign held_sample_o = sample_q;

endmodule

[rtl/core/tmadc_accum.sv]
// ---------------------------------------------------------------------------
// tmadc_accum
// Per-sample count, sum, max and min tracking; trims and averages.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tmadc_accum #(
  parameter int unsigned SampleWidth = tmadc_pkg::SampleWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [SampleWidth-1:0]        sample_i,
  input  tmadc_pkg::settle_t            settle_i,
  output logic                          emit_o,
  output tmadc_pkg::result_tag_t        tag_o,
  output logic [SampleWidth-1:0]        average_o
);
  import tmadc_pkg::*;

  localparam int unsigned SumWidth = SampleWidth + GuardBits;

  count_t                       count_q, count_d;
  logic signed [SumWidth-1:0]   sum_q, sum_d;
  logic signed [SampleWidth-1:0] max_q, max_d;
  logic signed [SampleWidth-1:0] min_q, min_d;
  logic                         chan_q, chan_d;

  count_t                        cnt_inc;
  count_t                        settle_ext;
  logic                          keep;
  logic                          first;
  logic signed [SampleWidth-1:0] x;
  logic signed [SumWidth-1:0]    x_ext;
  logic signed [SumWidth-1:0]    base_sum;
  logic signed [SampleWidth-1:0] base_max;
  logic signed [SampleWidth-1:0] base_min;
  logic signed [SumWidth-1:0]    sum_acc;
  logic signed [SampleWidth-1:0] max_acc;
  logic signed [SampleWidth-1:0] min_acc;
  logic signed [SumWidth-1:0]    trimmed;
  logic signed [SumWidth-1:0]    avg_sum;

  always_comb begin
    x          = $signed(sample_i);
    x_ext      = {{GuardBits{sample_i[SampleWidth-1]}}, sample_i};
    cnt_inc    = count_q + count_t'(1);
    settle_ext = {1'b0, settle_i};
    keep       = cnt_inc > settle_ext;
    first      = cnt_inc == (settle_ext + count_t'(1));
    emit_o     = cnt_inc > (settle_ext + count_t'(KeepCount - 1));

    // Restart the window on the first kept sample.
    base_sum = first ? '0 : sum_q;
    base_max = first ? x : max_q;
    base_min = first ? x : min_q;

    if (keep) begin
      sum_acc = base_sum + x_ext;
      max_acc = (base_max < x) ? x : base_max;
      min_acc = (base_min > x) ? x : base_min;
    end else begin
      sum_acc = sum_q;
      max_acc = max_q;
      min_acc = min_q;
    end

    // Drop the extremes, divide the remaining eight by eight.
    trimmed = sum_acc - {{GuardBits{max_acc[SampleWidth-1]}}, max_acc}
                      - {{GuardBits{min_acc[SampleWidth-1]}}, min_acc};
    avg_sum = trimmed >>> TrimShift;

    sum_d   = emit_o ? avg_sum : sum_acc;
    max_d   = max_acc;
    min_d   = min_acc;
    count_d = emit_o ? '0 : cnt_inc;
    chan_d  = emit_o ? ~chan_q : chan_q;
  end

  assign tag_o.channel    = chan_q;
  assign tag_o.round_done = chan_q;
  assign average_o        = avg_sum[SampleWidth-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      max_q   <= '0;
      min_q   <= '0;
      chan_q  <= 1'b0;
    end else if (step_i) begin
      count_q <= count_d;
      sum_q   <= sum_d;
      max_q   <= max_d;
      min_q   <= min_d;
      chan_q  <= chan_d;
    end
  end

  `TM_ASSERT(a_count_bounded, clk_i, rst_ni, count_q <= count_t'(MaxHeldCount))
  `TM_ASSERT(a_emit_switches, clk_i, rst_ni,
             (step_i && emit_o) |=> (count_q == '0) && (chan_q != $past(chan_q)))

endmodule

[rtl/core/tmadc_out_stage.sv]
// ---------------------------------------------------------------------------
// tmadc_out_stage
// Result register: holds one tagged average until the sink takes it.
// ---------------------------------------------------------------------------
module tmadc_out_stage #(
  parameter int unsigned SampleWidth = tmadc_pkg::SampleWidthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  tmadc_pkg::result_tag_t tag_i,
  input  logic [SampleWidth-1:0] average_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output tmadc_pkg::result_tag_t tag_o,
  output logic [SampleWidth-1:0] average_o
);
  import tmadc_pkg::*;

  logic                   valid_q;
  result_tag_t            tag_q;
  logic [SampleWidth-1:0] average_q;

  // Room for a new result when empty or once the held one leaves this cycle.
  assign free_o = ~valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      tag_q     <= tag_i;
      average_q <= average_i;
    end
  end

  assign out_valid_o = valid_q;
  assign tag_o       = tag_q;
  assign average_o   = average_q;

endmodule

[rtl/core/trimmed_mean_two_channel_adc.sv]
// ---------------------------------------------------------------------------
// trimmed_mean_two_channel_adc
// Trimmed-mean two-channel converter averager, one sample per cycle unless stalled.
// ---------------------------------------------------------------------------
// Feed one signed conversion result per transfer on the input channel. After
// each channel switch the block drops the first settle-discard samples, then
// sums the next ten while tracking their largest and smallest values; on the
// tenth kept sample it removes both extremes, shifts the remaining sum of
// eight right arithmetically by three and delivers that average with its
// channel tag. Channel 0 (second analog input) comes first, then channel 1
// (first analog input), whose result carries round_done. A sample is held in
// the input register and its result then lands in the result register. The
// block takes one sample every cycle unless a full result register under
// output stall holds it, the only throttle; samples that produce no result
// still flow past it. The settle-discard register sits on its own write
// port that is always ready; write it only while the block is idle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module trimmed_mean_two_channel_adc #(
  parameter int unsigned SampleWidth = tmadc_pkg::SampleWidthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // sample input
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [SampleWidth-1:0]    sample_i,
  // result output
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      channel_o,
  output logic [SampleWidth-1:0]    average_o,
  output logic                      round_done_o,
  // settle-discard register write
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  tmadc_pkg::settle_t        cfg_settle_discard_i
);
  import tmadc_pkg::*;

  settle_t                settle_q;
  logic                   held_valid;
  logic [SampleWidth-1:0] held_sample;
  logic                   consume;
  logic                   emit;
  logic                   out_free;
  result_tag_t            acc_tag;
  result_tag_t            out_tag;
  logic [SampleWidth-1:0] acc_average;

  // Settle-discard register; accept every write.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= SettleReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      settle_q <= cfg_settle_discard_i;
    end
  end

  // Advance the held sample unless it makes a result with nowhere to go.
  assign consume = held_valid & (~emit | out_free);

  tmadc_in_stage #(
    .SampleWidth(SampleWidth)
  ) u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .consume_i    (consume),
    .held_valid_o (held_valid),
    .held_sample_o(held_sample)
  );

  tmadc_accum #(
    .SampleWidth(SampleWidth)
  ) u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (consume),
    .sample_i (held_sample),
    .settle_i (settle_q),
    .emit_o   (emit),
    .tag_o    (acc_tag),
    .average_o(acc_average)
  );

  tmadc_out_stage #(
    .SampleWidth(SampleWidth)
  ) u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (consume & emit),
    .tag_i      (acc_tag),
    .average_i  (acc_average),
    .free_o     (out_free),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .tag_o      (out_tag),
    .average_o  (average_o)
  );

  assign channel_o    = out_tag.channel;
  assign round_done_o = out_tag.round_done;

  `TM_ASSERT(a_result_lands, clk_i, rst_ni, (consume && emit) |=> out_valid_o)
  `TM_ASSERT(a_round_on_first_input, clk_i, rst_ni,
             out_valid_o |-> (round_done_o == channel_o))

endmodule
